// ===== design/glet_pkg.sv =====
// shared types and constants of the gray laplacian edge threshold block
`default_nettype none
package glet_pkg;

  localparam int PIX_W      = 8;
  localparam int SIZE_CFG_W = 12;
  localparam int THR_W      = 8;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int SUM_W      = 18;
  localparam int PROD_W     = 16;
  localparam int LAP_W      = 11;
  localparam int STEP_W     = 4;
  localparam int MIN_SIZE   = 3;

  localparam logic [STEP_W-1:0] SQ_LAST    = 4'd2;
  localparam logic [STEP_W-1:0] READ_STEPS = 4'd4;

  localparam logic [SIZE_CFG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [SIZE_CFG_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [THR_W-1:0]      THR_RESET    = 8'd63;

  localparam logic [PIX_W-1:0] LEVEL_MAX = 8'hff;
  localparam logic [PIX_W-1:0] LEVEL_MIN = 8'h00;
  localparam logic [PIX_W-1:0] ROOT_MSB  = 8'h80;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_THRESHOLD = 2'd2,
    REG_NONE      = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_WRITE
  } state_t;

  typedef enum logic [1:0] {
    RD_UP     = 2'd0,
    RD_CENTRE = 2'd1,
    RD_LEFT   = 2'd2,
    RD_RIGHT  = 2'd3
  } rd_sel_t;

  typedef struct packed {
    logic [PIX_W-1:0] level;
    logic             last;
  } result_t;

endpackage
`default_nettype wire

// ===== design/glet_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none
module glet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/gray_laplacian_edge_threshold.sv =====
// top level: rgb to gray, two gray line stores in ram, 4-neighbour laplacian and threshold
//
// Pixels arrive in raster order, and pixel_stall stays high from each transfer until its
// write-back: the block takes the pixel, a single shared 8x8 multiplier sums the squares of
// red, green and blue, the bit-per-cycle square root runs on that same multiplier, and the
// write-back step writes the gray value back to the line ram and loads the results. The
// four line-ram reads (up, centre, left, right) overlap the arithmetic. Results sit in a
// two-entry output buffer; the write-back cycle waits until that buffer has drained, so a
// result side that stalls for more than the arithmetic time slows the input. Nothing comes
// out during the first row, one result (the pixel above) per pixel after it, and two (the
// pixel above, then the pixel itself) per pixel of the last row; frame_last marks the final
// one. Writing the width or height restarts the frame. The line ram holds no reset and
// needs no clearing.
`default_nettype none
module gray_laplacian_edge_threshold #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [glet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [glet_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           pixel_valid,
  output logic                                pixel_stall,
  input  wire logic [glet_pkg::PIX_W-1:0]      red,
  input  wire logic [glet_pkg::PIX_W-1:0]      green,
  input  wire logic [glet_pkg::PIX_W-1:0]      blue,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output logic      [glet_pkg::PIX_W-1:0]      out_level,
  output logic                                frame_last
);

  import glet_pkg::*;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int WSZ_W     = $clog2(MAX_WIDTH + 1);
  localparam int HSZ_W     = $clog2(MAX_HEIGHT + 1);
  localparam int WCMP_W    = (WSZ_W > SIZE_CFG_W) ? WSZ_W : SIZE_CFG_W;
  localparam int HCMP_W    = (HSZ_W > SIZE_CFG_W) ? HSZ_W : SIZE_CFG_W;
  localparam int WPOS_W    = WSZ_W + 1;
  localparam int HPOS_W    = HSZ_W + 1;
  localparam int RAM_DEPTH = 2 * (1 << COL_W);
  localparam int ADDR_W    = COL_W + 1;

  // configuration
  logic [SIZE_CFG_W-1:0] image_width;
  logic [SIZE_CFG_W-1:0] image_height;
  logic [THR_W-1:0]      edge_threshold;
  logic [WSZ_W-1:0]      w_eff;
  logic [HSZ_W-1:0]      h_eff;

  // frame position
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;

  // sequencer and arithmetic
  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [PIX_W-1:0]  red_q;
  logic [PIX_W-1:0]  green_q;
  logic [PIX_W-1:0]  blue_q;
  logic [SUM_W-1:0]  sum;
  logic [PIX_W-1:0]  root;
  logic [PIX_W-1:0]  root_bit;
  logic [PIX_W-1:0]  root_try;
  logic [PIX_W-1:0]  mul_op;
  logic [PROD_W-1:0] prod;

  // line ram
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [PIX_W-1:0]  ram_rdata;
  logic              rd_live;
  rd_sel_t           rd_sel;
  logic [PIX_W-1:0]  up_pix;
  logic [PIX_W-1:0]  centre_pix;
  logic [PIX_W-1:0]  left_pix;
  logic [PIX_W-1:0]  right_pix;
  logic [COL_W-1:0]  left_col;
  logic [COL_W-1:0]  right_col;

  // result computation
  logic                    accept;
  logic                    do_write;
  logic                    last_col;
  logic                    last_row;
  logic                    interior;
  logic signed [LAP_W-1:0] lap;
  logic [PIX_W-1:0]        lap_clamped;
  logic [PIX_W-1:0]        level;

  // output buffer
  result_t    slot0;
  result_t    slot1;
  logic [1:0] buf_count;
  logic       pop;

  // effective frame size, clamped to the supported range
  always_comb begin
    logic [WCMP_W-1:0] wc;
    logic [HCMP_W-1:0] hc;
    wc = WCMP_W'(image_width);
    hc = HCMP_W'(image_height);
    priority if (wc < WCMP_W'(MIN_SIZE)) begin
      w_eff = WSZ_W'(MIN_SIZE);
    end else if (wc > WCMP_W'(MAX_WIDTH)) begin
      w_eff = WSZ_W'(MAX_WIDTH);
    end else begin
      w_eff = WSZ_W'(wc);
    end
    priority if (hc < HCMP_W'(MIN_SIZE)) begin
      h_eff = HSZ_W'(MIN_SIZE);
    end else if (hc > HCMP_W'(MAX_HEIGHT)) begin
      h_eff = HSZ_W'(MAX_HEIGHT);
    end else begin
      h_eff = HSZ_W'(hc);
    end
  end

  assign last_col = (WPOS_W'(column_count) + WPOS_W'(1)) >= WPOS_W'(w_eff);
  assign last_row = (HPOS_W'(row_count) + HPOS_W'(1)) >= HPOS_W'(h_eff);
  assign interior = (row_count >= ROW_W'(2)) && (column_count != '0)
                    && ((WPOS_W'(column_count) + WPOS_W'(2)) <= WPOS_W'(w_eff));

  assign accept   = pixel_valid && !pixel_stall;
  assign do_write = (state == ST_WRITE) && (buf_count == 2'd0);
  assign pop      = result_valid && !result_stall;

  // shared multiplier: squares during ST_SQUARE, trial roots during ST_ROOT
  assign root_try = root | root_bit;
  always_comb begin
    unique case (state)
      ST_SQUARE: begin
        unique case (step[1:0])
          2'd0:    mul_op = red_q;
          2'd1:    mul_op = green_q;
          default: mul_op = blue_q;
        endcase
      end
      default: mul_op = root_try;
    endcase
  end
  assign prod = mul_op * mul_op;

  // read addresses; neighbours outside the row fall back to the centre column
  assign left_col  = (column_count == '0) ? column_count : column_count - COL_W'(1);
  assign right_col = last_col ? column_count : column_count + COL_W'(1);

  always_comb begin
    unique case (rd_sel_t'(step[1:0]))
      RD_UP:     ram_raddr = {row_count[0], column_count};
      RD_CENTRE: ram_raddr = {~row_count[0], column_count};
      RD_LEFT:   ram_raddr = {~row_count[0], left_col};
      RD_RIGHT:  ram_raddr = {~row_count[0], right_col};
    endcase
  end
  assign ram_waddr = {row_count[0], column_count};

  glet_ram #(
    .WIDTH (PIX_W),
    .DEPTH (RAM_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (root),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // laplacian of the pixel above, with the incoming gray as its lower neighbour
  always_comb begin
    lap = $signed(LAP_W'({centre_pix, 2'b00})) - $signed(LAP_W'(left_pix))
          - $signed(LAP_W'(right_pix)) - $signed(LAP_W'(up_pix)) - $signed(LAP_W'(root));
    priority if (lap < 0) begin
      lap_clamped = LEVEL_MIN;
    end else if (lap > $signed(LAP_W'(LEVEL_MAX))) begin
      lap_clamped = LEVEL_MAX;
    end else begin
      lap_clamped = lap[PIX_W-1:0];
    end
    if (interior) begin
      level = (lap_clamped > edge_threshold) ? LEVEL_MAX : LEVEL_MIN;
    end else begin
      level = centre_pix;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_SQUARE;
      ST_SQUARE: if (step == SQ_LAST) state_next = ST_ROOT;
      ST_ROOT:   if (root_bit[0]) state_next = ST_WRITE;
      ST_WRITE:  if (buf_count == 2'd0) state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pixel_stall = 1'b1;
    ram_we      = 1'b0;
    unique case (state)
      ST_IDLE:   pixel_stall = 1'b0;
      ST_SQUARE: pixel_stall = 1'b1;
      ST_ROOT:   pixel_stall = 1'b1;
      ST_WRITE:  ram_we      = do_write;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      image_width    <= WIDTH_RESET;
      image_height   <= HEIGHT_RESET;
      edge_threshold <= THR_RESET;
      column_count   <= '0;
      row_count      <= '0;
      rd_live        <= 1'b0;
      buf_count      <= 2'd0;
    end else begin
      state   <= state_next;
      rd_live <= ((state == ST_SQUARE) || (state == ST_ROOT)) && (step < READ_STEPS);
      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_WIDTH: begin
            image_width  <= cfg_data[SIZE_CFG_W-1:0];
            column_count <= '0;
            row_count    <= '0;
          end
          REG_HEIGHT: begin
            image_height <= cfg_data[SIZE_CFG_W-1:0];
            column_count <= '0;
            row_count    <= '0;
          end
          REG_THRESHOLD: edge_threshold <= cfg_data[THR_W-1:0];
          REG_NONE: ;
        endcase
      end
      if (do_write) begin
        if (last_col) begin
          column_count <= '0;
          row_count    <= last_row ? '0 : row_count + ROW_W'(1);
        end else begin
          column_count <= column_count + COL_W'(1);
        end
        if (row_count != '0) begin
          buf_count <= last_row ? 2'd2 : 2'd1;
        end else begin
          buf_count <= last_row ? 2'd1 : 2'd0;
        end
      end else if (pop) begin
        buf_count <= buf_count - 2'd1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rd_sel <= rd_sel_t'(step[1:0]);
    if (rd_live) begin
      unique case (rd_sel)
        RD_UP:     up_pix     <= ram_rdata;
        RD_CENTRE: centre_pix <= ram_rdata;
        RD_LEFT:   left_pix   <= ram_rdata;
        RD_RIGHT:  right_pix  <= ram_rdata;
      endcase
    end
    if (accept) begin
      red_q   <= red;
      green_q <= green;
      blue_q  <= blue;
      step    <= '0;
      sum     <= '0;
      root    <= '0;
    end
    if (state == ST_SQUARE) begin
      sum  <= sum + SUM_W'(prod);
      step <= step + STEP_W'(1);
      if (step == SQ_LAST) begin
        root_bit <= ROOT_MSB;
      end
    end
    if (state == ST_ROOT) begin
      // one result bit per cycle; sums past 255 squared end at 255
      if (SUM_W'(prod) <= sum) begin
        root <= root_try;
      end
      root_bit <= root_bit >> 1;
      step     <= step + STEP_W'(1);
    end
    if (do_write) begin
      if (row_count != '0) begin
        slot0 <= '{level: level, last: 1'b0};
        slot1 <= '{level: root, last: last_col};
      end else begin
        slot0 <= '{level: root, last: last_col};
      end
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  assign result_valid = (buf_count != 2'd0);
  assign out_level    = slot0.level;
  assign frame_last   = slot0.last;

  // results are only loaded into an empty buffer
  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    do_write |-> !result_valid)
    else $error("output buffer loaded while holding results");

  // a transfer always starts the sum of squares
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SQUARE) && (step == '0))
    else $error("pixel transfer did not start the sequencer");

  // column stays inside the frame width
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    WPOS_W'(column_count) < WPOS_W'(w_eff))
    else $error("column count beyond frame width");

  // the root search walks exactly one bit at a time
  a_root_bit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROOT) |-> $onehot(root_bit))
    else $error("square root bit lost");

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// self-checking testbench for gray_laplacian_edge_threshold: directed table then random frames
module tb_top;
  import glet_pkg::*;

  localparam int MAX_W         = 2048;
  localparam int MAX_H         = 2048;
  localparam int RANDOM_PIXELS = 630;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_MAX    = 10;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    cfg_reg_t              idx;
    logic [CFG_DATA_W-1:0] data;
    logic [PIX_W-1:0]      r;
    logic [PIX_W-1:0]      g;
    logic [PIX_W-1:0]      b;
    logic                  typed;
    logic [PIX_W-1:0]      level;
    logic                  last;
  } plan_row_t;

  logic                  clk;
  logic                  rst          = 1'b1;
  logic                  cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  pixel_valid  = 1'b0;
  logic                  pixel_stall;
  logic [PIX_W-1:0]      red          = '0;
  logic [PIX_W-1:0]      green        = '0;
  logic [PIX_W-1:0]      blue         = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [PIX_W-1:0]      out_level;
  logic                  frame_last;

  // no random idling on either side while set
  logic steady = 1'b0;

  // shadow of the block: registers, line store and raster position
  logic [SIZE_CFG_W-1:0] width_cfg  = WIDTH_RESET;
  logic [SIZE_CFG_W-1:0] height_cfg = HEIGHT_RESET;
  logic [THR_W-1:0]      thr_cfg    = THR_RESET;
  logic [PIX_W-1:0]      line_gray [0:2*MAX_W-1];
  int                    col_pos    = 0;
  int                    row_pos    = 0;

  result_t level_q[$];
  int      mismatches = 0;
  int      cycles     = 0;

  gray_laplacian_edge_threshold u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_level    (out_level),
    .frame_last   (frame_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int clamp_dim(logic [SIZE_CFG_W-1:0] v, int hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic int store_at(int row, int col);
    return (row % 2) * MAX_W + col;
  endfunction

  // largest root whose square fits the sum of squares, capped at 255
  function automatic int gray_level(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                    logic [PIX_W-1:0] b);
    int sum;
    int root;
    sum  = int'(r) * int'(r) + int'(g) * int'(g) + int'(b) * int'(b);
    root = 0;
    while (root < 255 && (root + 1) * (root + 1) <= sum) root++;
    return root;
  endfunction

  function automatic plan_row_t cfg_row(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.data = data;
    return row;
  endfunction

  function automatic plan_row_t pix_row(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                        logic [PIX_W-1:0] b);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_PIX;
    row.r    = r;
    row.g    = g;
    row.b    = b;
    return row;
  endfunction

  // pixel whose final result is known by inspection
  function automatic plan_row_t typed_row(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                          logic [PIX_W-1:0] b, logic [PIX_W-1:0] level,
                                          logic last);
    plan_row_t row;
    row       = pix_row(r, g, b);
    row.typed = 1'b1;
    row.level = level;
    row.last  = last;
    return row;
  endfunction

  // queue the results one accepted pixel produces and advance the raster position
  task automatic predict_levels(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                logic [PIX_W-1:0] b);
    int      w;
    int      h;
    int      gray;
    int      up;
    int      centre;
    int      left;
    int      right;
    int      lap;
    result_t res;
    w    = clamp_dim(width_cfg, MAX_W);
    h    = clamp_dim(height_cfg, MAX_H);
    gray = gray_level(r, g, b);
    up   = 0;
    if (row_pos >= 2) up = int'(line_gray[store_at(row_pos, col_pos)]);
    if (row_pos >= 1) begin
      centre    = int'(line_gray[store_at(row_pos - 1, col_pos)]);
      res.level = centre[PIX_W-1:0];
      res.last  = 1'b0;
      if (row_pos >= 2 && col_pos >= 1 && col_pos + 2 <= w) begin
        left  = int'(line_gray[store_at(row_pos - 1, col_pos - 1)]);
        right = int'(line_gray[store_at(row_pos - 1, col_pos + 1)]);
        lap   = 4 * centre - left - right - up - gray;
        if (lap < 0) lap = 0;
        if (lap > 255) lap = 255;
        res.level = (lap > int'(thr_cfg)) ? LEVEL_MAX : LEVEL_MIN;
      end
      level_q.push_back(res);
    end
    line_gray[store_at(row_pos, col_pos)] = gray[PIX_W-1:0];
    // last row: the pixel itself follows the one above it
    if (row_pos + 1 >= h) begin
      res.level = gray[PIX_W-1:0];
      res.last  = (col_pos + 1 >= w);
      level_q.push_back(res);
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  // register write once the block has drained and gone quiet
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    pixel_valid <= 1'b0;
    while (level_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_WIDTH: begin
        width_cfg = data;
        col_pos   = 0;
        row_pos   = 0;
      end
      REG_HEIGHT: begin
        height_cfg = data;
        col_pos    = 0;
        row_pos    = 0;
      end
      REG_THRESHOLD: thr_cfg = data[THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
    while (!steady && $urandom_range(99) < 15) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
    pixel_valid <= 1'b1;
    red         <= r;
    green       <= g;
    blue        <= b;
    @(posedge clk);
    while (pixel_stall !== 1'b0) @(posedge clk);
    predict_levels(r, g, b);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    result_stall <= !steady && ($urandom_range(99) < 15);
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      got.level = out_level;
      got.last  = frame_last;
      if (level_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result transfer: level %0d last %0d", got.level, got.last);
      end else begin
        want = level_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("result mismatch: expected level %0d last %0d, got level %0d last %0d",
                     want.level, want.last, got.level, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    plan_row_t        plan[$];
    result_t          typed_res;
    int               w;
    int               h;
    int               count;
    int               style;
    int               base;
    int               pick;
    int               tmp;
    int               sent;
    int               phase;
    logic [PIX_W-1:0] comp [0:2];

    // sizes below the minimum clamp to 3; the threshold keeps its reset value
    plan.push_back(cfg_row(REG_WIDTH, 12'd0));
    plan.push_back(cfg_row(REG_HEIGHT, 12'd2));
    plan.push_back(pix_row(8'd0, 8'd0, 8'd0));
    plan.push_back(pix_row(8'd255, 8'd255, 8'd255));
    plan.push_back(pix_row(8'd255, 8'd0, 8'd0));
    plan.push_back(typed_row(8'd0, 8'd255, 8'd0, 8'd0, 1'b0));
    plan.push_back(typed_row(8'd0, 8'd0, 8'd255, 8'd255, 1'b0));
    plan.push_back(typed_row(8'd1, 8'd1, 8'd1, 8'd255, 1'b0));
    plan.push_back(typed_row(8'd128, 8'd128, 8'd128, 8'd221, 1'b0));
    plan.push_back(typed_row(8'd255, 8'd255, 8'd255, 8'd255, 1'b0));
    plan.push_back(typed_row(8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    // zero threshold, height above the maximum, so no last row comes
    plan.push_back(cfg_row(REG_THRESHOLD, 12'h000));
    plan.push_back(cfg_row(REG_HEIGHT, 12'hfff));
    plan.push_back(pix_row(8'd3, 8'd4, 8'd0));
    plan.push_back(pix_row(8'd200, 8'd150, 8'd0));
    plan.push_back(pix_row(8'd180, 8'd180, 8'd180));
    plan.push_back(typed_row(8'd10, 8'd10, 8'd10, 8'd5, 1'b0));
    plan.push_back(typed_row(8'd255, 8'd0, 8'd0, 8'd250, 1'b0));
    plan.push_back(typed_row(8'd0, 8'd0, 8'd1, 8'd255, 1'b0));
    plan.push_back(typed_row(8'd0, 8'd0, 8'd0, 8'd17, 1'b0));
    plan.push_back(pix_row(8'd7, 8'd24, 8'd0));
    plan.push_back(typed_row(8'd100, 8'd0, 8'd0, 8'd1, 1'b0));
    // mid-frame size writes restart the frame; width clamps to the maximum
    plan.push_back(cfg_row(REG_HEIGHT, 12'd3));
    plan.push_back(cfg_row(REG_WIDTH, 12'hfff));
    plan.push_back(cfg_row(REG_THRESHOLD, 12'hfff));
    plan.push_back(pix_row(8'd17, 8'd34, 8'd68));
    plan.push_back(pix_row(8'd136, 8'd15, 8'd240));
    plan.push_back(pix_row(8'd85, 8'd170, 8'd85));
    plan.push_back(pix_row(8'd170, 8'd85, 8'd170));
    // unused index is ignored
    plan.push_back(cfg_row(REG_NONE, 12'd5));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_pixel(plan[i].r, plan[i].g, plan[i].b);
        if (plan[i].typed) begin
          typed_res.level = plan[i].level;
          typed_res.last  = plan[i].last;
          level_q[level_q.size() - 1] = typed_res;
        end
      end
    end

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_PIXELS) begin
      phase++;
      steady <= (phase >= 8 && phase <= 13);
      pick = $urandom_range(99);
      if (pick < 20) begin
        // threshold change only, the frame carries on
        write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(4095)));
        if (pick < 6) write_reg(REG_NONE, CFG_DATA_W'($urandom_range(4095)));
      end else begin
        if (pick < 80) begin
          tmp = $urandom_range(99);
          if (tmp < 60) tmp = $urandom_range(3, 6);
          else if (tmp < 80) tmp = $urandom_range(7, 20);
          else if (tmp < 88) tmp = $urandom_range(0, 2);
          else if (tmp < 94) tmp = $urandom_range(21, 60);
          else tmp = $urandom_range(2048, 4095);
          write_reg(REG_WIDTH, CFG_DATA_W'(tmp));
        end
        if (pick >= 50) begin
          tmp = $urandom_range(99);
          if (tmp < 70) tmp = $urandom_range(3, 5);
          else if (tmp < 85) tmp = $urandom_range(6, 9);
          else if (tmp < 92) tmp = $urandom_range(0, 2);
          else tmp = $urandom_range(10, 4095);
          write_reg(REG_HEIGHT, CFG_DATA_W'(tmp));
        end
        tmp = $urandom_range(99);
        if (tmp < 25) write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(15)));
        else if (tmp < 35) write_reg(REG_THRESHOLD, {4'($urandom_range(15)), 8'hff});
        else if (tmp < 60) write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(4095)));
      end

      w = clamp_dim(width_cfg, MAX_W);
      h = clamp_dim(height_cfg, MAX_H);
      if (w * h <= 160 && $urandom_range(99) < 70) count = w * h * $urandom_range(1, 2);
      else count = $urandom_range(1, 40);
      if (count > RANDOM_PIXELS - sent) count = RANDOM_PIXELS - sent;

      // plain noise, saturated extremes, or nearly flat areas near the threshold
      style = $urandom_range(2);
      base  = $urandom_range(255);
      repeat (count) begin
        for (int k = 0; k < 3; k++) begin
          case (style)
            0: comp[k] = PIX_W'($urandom_range(255));
            1: begin
              tmp = $urandom_range(2);
              comp[k] = (tmp == 0) ? LEVEL_MIN :
                        (tmp == 1) ? LEVEL_MAX : PIX_W'($urandom_range(255));
            end
            default: begin
              tmp = base + $urandom_range(8) - 4;
              if (tmp < 0) tmp = 0;
              if (tmp > 255) tmp = 255;
              comp[k] = tmp[PIX_W-1:0];
            end
          endcase
        end
        send_pixel(comp[0], comp[1], comp[2]);
        sent++;
      end
    end

    pixel_valid <= 1'b0;
    while (level_q.size() != 0) @(negedge clk);
    repeat (2 * SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/glet_pkg.sv
design/glet_ram.sv
design/gray_laplacian_edge_threshold.sv
bench/tb_top.sv
